[rtl/clf_pkg.sv]
`default_nettype none
package clf_pkg;
    localparam int MAX_PEAKS = 64;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [2:0] REG_BOTTOM = 3'd0;
    localparam logic [2:0] REG_LEVEL  = 3'd1;
    localparam logic [2:0] REG_CONES  = 3'd2;
    localparam logic [2:0] REG_COUNT  = 3'd3;
    localparam logic [2:0] REG_GLOBAL = 3'd4;

    localparam logic [40:0] PROD_CLAMP = 41'h100_0000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         peak_index;
        logic signed [31:0] peak_height;
        logic signed [31:0] peak_slope;
        logic signed [31:0] peak_x;
        logic signed [31:0] peak_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } req_t;

    typedef struct packed {
        logic signed [31:0] fitness;
        logic [6:0]         best_peak;
        logic               on_peak;
        logic [31:0]        hit_total;
        logic [31:0]        eval_total;
        logic [6:0]         covered_total;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] bottom_level;
        logic signed [31:0] peak_level;
        logic               use_cones;
        logic [6:0]         peak_count;
        logic [6:0]         global_count;
    } cfg_t;
endpackage
`default_nettype wire

[rtl/clf_front.sv]
`default_nettype none
module clf_front
    import clf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire req_t        in_req,
    output logic             q_valid,
    input  wire logic        q_ready,
    output req_t             q_req
);
    localparam int DEPTH = 2;

    req_t       buf_reg [DEPTH];
    logic [0:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_req;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2) else $error("queue overfilled");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1 && pop && !push) |=> !q_valid) else $error("queue drain");
endmodule
`default_nettype wire

[rtl/clf_back.sv]
`default_nettype none
module clf_back
    import clf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire req_t q_req,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_rsp
);
    localparam int IW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SCORE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;
    localparam logic [2:0] ST_COVER = 3'd7;

    logic signed [31:0] h_mem [MAX_PEAKS];
    logic signed [31:0] s_mem [MAX_PEAKS];
    logic signed [31:0] x_mem [MAX_PEAKS];
    logic signed [31:0] y_mem [MAX_PEAKS];
    logic [MAX_PEAKS-1:0] cov_reg;

    logic [2:0]  st_reg;
    req_t        cur_reg;
    logic [6:0]  idx_reg, n_reg;
    logic        busy_reg;
    logic signed [31:0] h_rd, s_rd, x_rd, y_rd;
    logic [63:0] sx_reg, sy_reg;
    logic [64:0] sum_reg;
    logic [5:0]  it_reg;
    logic [66:0] rem_reg;
    logic [32:0] root_reg;
    logic [48:0] d_reg;
    logic [63:0] plo_reg;
    logic [48:0] phi_reg;
    logic [81:0] prod_reg;
    logic signed [31:0] best_reg;
    logic [6:0]  win_reg;
    logic [31:0] hit_reg, evl_reg;
    logic [6:0]  covc_reg;
    logic        ov_reg;
    rsp_t        o_reg;

    logic [31:0] ax, ay;
    logic [66:0] rem_sh, trial;
    logic [1:0]  pair;
    logic [31:0] mag;
    logic [40:0] pclamp;
    logic signed [42:0] sc_wide;
    logic signed [31:0] sc;
    logic        hit;
    logic [6:0]  nuse, gcap;
    logic [IW-1:0] rd_idx;

    assign q_ready   = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_rsp   = o_reg;
    assign rd_idx    = idx_reg[IW-1:0];

    always_comb
    begin
        ax = (cur_reg.point_x >= x_rd) ? 32'(cur_reg.point_x - x_rd) : 32'(x_rd - cur_reg.point_x);
        ay = (cur_reg.point_y >= y_rd) ? 32'(cur_reg.point_y - y_rd) : 32'(y_rd - cur_reg.point_y);
        pair   = (it_reg == 6'd32) ? {1'b0, sum_reg[64]} : 2'(sum_reg >> (2 * it_reg));
        rem_sh = {rem_reg[64:0], pair};
        trial  = {32'd0, root_reg, 2'b01};
        mag    = s_rd[31] ? 32'(-s_rd) : 32'(s_rd);
        pclamp = (prod_reg[81:16] > 66'(PROD_CLAMP)) ? PROD_CLAMP : prod_reg[56:16];
        sc_wide = s_rd[31] ? 43'(h_rd) + $signed({2'b00, pclamp})
                           : 43'(h_rd) - $signed({2'b00, pclamp});
        if (sc_wide > 43'sd2147483647)
            sc = 32'sh7FFFFFFF;
        else if (sc_wide < -43'sd2147483648)
            sc = 32'sh80000000;
        else
            sc = sc_wide[31:0];
        nuse = (cfg.peak_count > 7'(MAX_PEAKS)) ? 7'(MAX_PEAKS) : cfg.peak_count;
        gcap = (cfg.global_count < nuse) ? cfg.global_count : nuse;
        hit  = (win_reg < nuse) && (win_reg < cfg.global_count)
               && (best_reg >= cfg.peak_level);
    end

    always_ff @(posedge clk)
    begin
        h_rd <= h_mem[rd_idx];
        s_rd <= s_mem[rd_idx];
        x_rd <= x_mem[rd_idx];
        y_rd <= y_mem[rd_idx];
        if (q_valid && q_ready && q_req.operation == OP_LOAD
            && {1'b0, q_req.peak_index} < 7'(MAX_PEAKS))
        begin
            h_mem[IW'(q_req.peak_index)] <= q_req.peak_height;
            s_mem[IW'(q_req.peak_index)] <= q_req.peak_slope;
            x_mem[IW'(q_req.peak_index)] <= q_req.peak_x;
            y_mem[IW'(q_req.peak_index)] <= q_req.peak_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            cov_reg  <= '0;
            hit_reg  <= '0;
            evl_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        cur_reg <= q_req;
                        o_reg   <= '0;
                        idx_reg <= '0;
                        case (q_req.operation)
                            OP_EVAL:
                            begin
                                best_reg <= cfg.bottom_level;
                                win_reg  <= 7'(MAX_PEAKS);
                                n_reg    <= nuse;
                                st_reg   <= (nuse == 7'd0) ? ST_DONE : ST_READ;
                            end
                            OP_CLOSE:
                            begin
                                covc_reg <= '0;
                                n_reg    <= gcap;
                                st_reg   <= ST_COVER;
                            end
                            default:
                                ov_reg <= 1'b1;
                        endcase
                    end
                end
                ST_READ:
                    st_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    sx_reg   <= 64'(ax) * 64'(ax);
                    sy_reg   <= 64'(ay) * 64'(ay);
                    busy_reg <= !busy_reg;
                    if (busy_reg)
                    begin
                        sum_reg  <= 65'(sx_reg) + 65'(sy_reg);
                        rem_reg  <= '0;
                        root_reg <= '0;
                        it_reg   <= 6'd32;
                        st_reg   <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (!cfg.use_cones)
                    begin
                        d_reg  <= 49'(sum_reg >> 16);
                        st_reg <= ST_MUL;
                    end
                    else
                    begin
                        if (rem_sh >= trial)
                        begin
                            rem_reg  <= rem_sh - trial;
                            root_reg <= {root_reg[31:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_sh;
                            root_reg <= {root_reg[31:0], 1'b0};
                        end
                        if (it_reg == 6'd0)
                        begin
                            d_reg  <= 49'(rem_sh >= trial ? {root_reg[31:0], 1'b1}
                                                          : {root_reg[31:0], 1'b0});
                            st_reg <= ST_MUL;
                        end
                        else
                            it_reg <= it_reg - 6'd1;
                    end
                end
                ST_MUL:
                begin
                    plo_reg  <= 64'(mag) * 64'(d_reg[31:0]);
                    phi_reg  <= 49'(mag) * 49'(d_reg[48:32]);
                    busy_reg <= !busy_reg;
                    if (busy_reg)
                    begin
                        prod_reg <= 82'({phi_reg, 32'd0}) + 82'(plo_reg);
                        st_reg   <= ST_SCORE;
                    end
                end
                ST_SCORE:
                begin
                    if (sc > best_reg)
                    begin
                        best_reg <= sc;
                        win_reg  <= idx_reg;
                    end
                    if (idx_reg + 7'd1 >= n_reg)
                        st_reg <= ST_DONE;
                    else
                    begin
                        idx_reg <= idx_reg + 7'd1;
                        st_reg  <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    o_reg.fitness   <= best_reg;
                    o_reg.best_peak <= win_reg;
                    o_reg.on_peak   <= hit;
                    o_reg.hit_total <= (hit && hit_reg != '1) ? hit_reg + 32'd1 : hit_reg;
                    o_reg.eval_total <= (evl_reg != '1) ? evl_reg + 32'd1 : evl_reg;
                    if (hit && hit_reg != '1)
                        hit_reg <= hit_reg + 32'd1;
                    if (evl_reg != '1)
                        evl_reg <= evl_reg + 32'd1;
                    if (hit)
                        cov_reg[win_reg[IW-1:0]] <= 1'b1;
                    ov_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                ST_COVER:
                begin
                    if (idx_reg >= n_reg)
                    begin
                        o_reg.hit_total     <= hit_reg;
                        o_reg.eval_total    <= evl_reg;
                        o_reg.covered_total <= covc_reg;
                        hit_reg <= '0;
                        evl_reg <= '0;
                        cov_reg <= '0;
                        ov_reg  <= 1'b1;
                        st_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        covc_reg <= covc_reg + 7'(cov_reg[rd_idx]);
                        idx_reg  <= idx_reg + 7'd1;
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !q_ready) else $error("accepted while busy");
    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DONE) |-> (win_reg <= 7'(MAX_PEAKS))) else $error("winner range");
    a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_SCORE) |=> $stable(hit_reg)) else $error("hit count moved in scan");
endmodule
`default_nettype wire

[rtl/cone_landscape_fitness_core.sv]
// channel | signals                                   | accepted when
// in      | in_valid/in_ready, operation..point_y     | in_valid && in_ready
// out     | out_valid/out_ready, fitness..covered_total | out_valid && out_ready
// cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | psel && penable && pwrite
// Evaluate: in cone mode each peak in use takes a 33-bit root from the shared root unit,
// one bit a cycle; otherwise the scaled squared distance is used and no root is taken.
// Load writes the peak table on acceptance. Close scans min(global_count, peaks in use) flags.
// Reset clears counters, covered flags and queue and sets config to defaults; peak table is not cleared.
// A two-entry request queue lets input continue while a result waits.
`default_nettype none
module cone_landscape_fitness_core
    import clf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [5:0]  peak_index,
    input  wire logic signed [31:0] peak_height,
    input  wire logic signed [31:0] peak_slope,
    input  wire logic signed [31:0] peak_x,
    input  wire logic signed [31:0] peak_y,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] fitness,
    output logic [6:0]       best_peak,
    output logic             on_peak,
    output logic [31:0]      hit_total,
    output logic [31:0]      eval_total,
    output logic [6:0]       covered_total,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cfg_t cfg_reg;
    req_t in_req, q_req;
    rsp_t rsp;
    logic q_valid, q_ready;
    logic [2:0] ra;

    assign pready = 1'b1;
    assign ra = paddr[4:2];
    assign in_req = '{operation, peak_index, peak_height, peak_slope,
                      peak_x, peak_y, point_x, point_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{32'sd0, 32'sd0, 1'b1, 7'd1, 7'd1};
        end
        else if (psel && penable && pwrite)
        begin
            case (ra)
                REG_BOTTOM: cfg_reg.bottom_level <= pwdata;
                REG_LEVEL:  cfg_reg.peak_level   <= pwdata;
                REG_CONES:  cfg_reg.use_cones    <= pwdata[0];
                REG_COUNT:  cfg_reg.peak_count   <= pwdata[6:0];
                REG_GLOBAL: cfg_reg.global_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ra)
            REG_BOTTOM: prdata = cfg_reg.bottom_level;
            REG_LEVEL:  prdata = cfg_reg.peak_level;
            REG_CONES:  prdata = {31'd0, cfg_reg.use_cones};
            REG_COUNT:  prdata = {25'd0, cfg_reg.peak_count};
            REG_GLOBAL: prdata = {25'd0, cfg_reg.global_count};
            default:    prdata = '0;
        endcase
    end

    clf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    clf_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_req(q_req), .out_valid(out_valid),
        .out_ready(out_ready), .out_rsp(rsp)
    );

    assign fitness       = rsp.fitness;
    assign best_peak     = rsp.best_peak;
    assign on_peak       = rsp.on_peak;
    assign hit_total     = rsp.hit_total;
    assign eval_total    = rsp.eval_total;
    assign covered_total = rsp.covered_total;

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(fitness))
        else $error("result dropped");
    a_cfg_cones: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && ra == REG_CONES) |=> cfg_reg.use_cones == $past(pwdata[0]))
        else $error("config write lost");
endmodule
`default_nettype wire

[bench/tb_cone_landscape_fitness_core.sv]
`timescale 1ns / 1ps
module tb_cone_landscape_fitness_core;
    import clf_pkg::*;

    localparam int NPEAK = 64;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] operation;
    logic [5:0] peak_index;
    logic signed [31:0] peak_height, peak_slope, peak_x, peak_y, point_x, point_y;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] fitness;
    logic [6:0] best_peak;
    logic on_peak;
    logic [31:0] hit_total, eval_total;
    logic [6:0] covered_total;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    cone_landscape_fitness_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .peak_index(peak_index),
        .peak_height(peak_height), .peak_slope(peak_slope),
        .peak_x(peak_x), .peak_y(peak_y),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .fitness(fitness), .best_peak(best_peak), .on_peak(on_peak),
        .hit_total(hit_total), .eval_total(eval_total),
        .covered_total(covered_total),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // landscape mirror
    logic signed [31:0] tab_h [NPEAK];
    logic signed [31:0] tab_r [NPEAK];
    logic signed [31:0] tab_x [NPEAK];
    logic signed [31:0] tab_y [NPEAK];
    bit covered [NPEAK];
    logic [31:0] hits, evals;
    cfg_t cfg;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int errors = 0;
    int n_sent = 0, n_recv = 0, n_eval = 0, n_hit = 0, n_close = 0;
    bit quiet = 0;
    bit hold_out = 0;
    int hold_out_cycles = 0;
    bit in_acc = 0;

    function automatic logic [63:0] isqrt(logic [64:0] v);
        logic [65:0] rem;
        logic [65:0] trial;
        logic [63:0] root;
        rem = 0;
        root = 0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | ((v >> (2 * k)) & 65'd3);
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint score_of(int i, longint px, longint py);
        longint dx, dy;
        logic [63:0] ax, ay, sx, sy, d, m, dh, dl, prod;
        logic [64:0] sum;
        longint r;
        dx = px - longint'(tab_x[i]);
        dy = py - longint'(tab_y[i]);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sx = ax * ax;
        sy = ay * ay;
        if (cfg.use_cones) begin
            sum = {1'b0, sx} + {1'b0, sy};
            d = isqrt(sum);
        end else begin
            d = (sx >> 16) + (sy >> 16) + (((sx & 64'hFFFF) + (sy & 64'hFFFF)) >> 16);
        end
        r = longint'(tab_r[i]);
        m = r < 0 ? -r : r;
        dh = d >> 16;
        dl = d & 64'hFFFF;
        if (dh != 0 && m > (64'h100_0000_0000 / dh)) prod = 64'h100_0000_0000;
        else begin
            prod = m * dh + ((m * dl) >> 16);
            if (prod > 64'h100_0000_0000) prod = 64'h100_0000_0000;
        end
        if (r < 0) return clip32(longint'(tab_h[i]) + longint'(prod));
        return clip32(longint'(tab_h[i]) - longint'(prod));
    endfunction

    function automatic rsp_t landscape_step(req_t q);
        rsp_t o;
        longint best, s;
        int n, g, win;
        o = '0;
        n = cfg.peak_count > NPEAK ? NPEAK : int'(cfg.peak_count);
        case (q.operation)
            OP_LOAD:
            begin
                tab_h[q.peak_index] = q.peak_height;
                tab_r[q.peak_index] = q.peak_slope;
                tab_x[q.peak_index] = q.peak_x;
                tab_y[q.peak_index] = q.peak_y;
            end
            OP_EVAL:
            begin
                best = longint'(cfg.bottom_level);
                win = NPEAK;
                for (int i = 0; i < n; i++) begin
                    s = score_of(i, longint'(q.point_x), longint'(q.point_y));
                    if (s > best) begin
                        best = s;
                        win = i;
                    end
                end
                if (win < n && win < int'(cfg.global_count)
                    && best >= longint'(cfg.peak_level)) begin
                    o.on_peak = 1'b1;
                    if (hits != 32'hFFFF_FFFF) hits++;
                    covered[win] = 1;
                end
                if (evals != 32'hFFFF_FFFF) evals++;
                o.fitness = best[31:0];
                o.best_peak = win[6:0];
                o.hit_total = hits;
                o.eval_total = evals;
            end
            OP_CLOSE:
            begin
                g = int'(cfg.global_count) < n ? int'(cfg.global_count) : n;
                for (int i = 0; i < g; i++) if (covered[i]) o.covered_total++;
                o.hit_total = hits;
                o.eval_total = evals;
                hits = 0;
                evals = 0;
                foreach (covered[i]) covered[i] = 0;
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver
    int in_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_acc) void'(pending_reqs.pop_front());
            if (in_valid && !in_acc) begin
                in_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                in_valid <= 1'b1;
                {operation, peak_index, peak_height, peak_slope, peak_x, peak_y,
                 point_x, point_y} <= pending_reqs[0];
                if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 16);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t e;
        in_acc = rst_n && in_valid && in_ready;
        if (in_acc) begin
            e = landscape_step(req_t'({operation, peak_index,
                peak_height, peak_slope, peak_x, peak_y, point_x, point_y}));
            expected_rsps.insert(expected_rsps.size(), e);
            n_sent++;
        end
    end

    // receiver
    int out_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_out && hold_out_cycles < 2000) begin
            hold_out_cycles <= hold_out_cycles + 1;
            out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 16);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n && out_valid && out_ready) begin
            n_recv++;
            if (expected_rsps.size() == 0) begin
                $error("result with none expected");
                errors++;
            end else begin
                w = expected_rsps.pop_front();
                if (fitness !== w.fitness) begin
                    $error("fitness exp %0d got %0d", w.fitness, fitness); errors++;
                end
                if (best_peak !== w.best_peak) begin
                    $error("best_peak exp %0d got %0d", w.best_peak, best_peak); errors++;
                end
                if (on_peak !== w.on_peak) begin
                    $error("on_peak exp %0d got %0d", w.on_peak, on_peak); errors++;
                end
                if (hit_total !== w.hit_total) begin
                    $error("hit_total exp %0d got %0d", w.hit_total, hit_total); errors++;
                end
                if (eval_total !== w.eval_total) begin
                    $error("eval_total exp %0d got %0d", w.eval_total, eval_total);
                    errors++;
                end
                if (covered_total !== w.covered_total) begin
                    $error("covered_total exp %0d got %0d", w.covered_total,
                        covered_total);
                    errors++;
                end
                if (w.on_peak) n_hit++;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BOTTOM: cfg.bottom_level = val;
            REG_LEVEL: cfg.peak_level = val;
            REG_CONES: cfg.use_cones = val[0];
            REG_COUNT: cfg.peak_count = val[6:0];
            REG_GLOBAL: cfg.global_count = val[6:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord(int span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    task automatic push_load(int idx, logic [31:0] h, logic [31:0] r,
                             logic [31:0] x, logic [31:0] y);
        req_t q;
        q = '0;
        q.operation = OP_LOAD;
        q.peak_index = 6'(idx);
        q.peak_height = h;
        q.peak_slope = r;
        q.peak_x = x;
        q.peak_y = y;
        q.point_x = $urandom;
        q.point_y = $urandom;
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic push_eval(logic [31:0] x, logic [31:0] y);
        req_t q;
        q = '0;
        q.operation = OP_EVAL;
        q.point_x = x;
        q.point_y = y;
        q.peak_index = 6'($urandom);
        q.peak_height = $urandom;
        q.peak_slope = $urandom;
        q.peak_x = $urandom;
        q.peak_y = $urandom;
        pending_reqs.insert(pending_reqs.size(), q);
        n_eval++;
    endtask

    task automatic push_op(logic [1:0] op);
        req_t q;
        q = '0;
        q.operation = op;
        q.peak_index = 6'($urandom);
        q.peak_height = $urandom;
        q.peak_slope = $urandom;
        q.peak_x = $urandom;
        q.peak_y = $urandom;
        q.point_x = $urandom;
        q.point_y = $urandom;
        pending_reqs.insert(pending_reqs.size(), q);
        if (op == OP_CLOSE) n_close++;
    endtask

    task automatic load_all;
        for (int i = 0; i < NPEAK; i++)
            push_load(i, $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h0004_0000),
                rnd_coord(32'h0080_0000), rnd_coord(32'h0080_0000));
    endtask

    initial
    begin
        int phase_n;
        int total;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {operation, peak_index, peak_height, peak_slope, peak_x, peak_y,
         point_x, point_y} = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg.bottom_level = 0;
        cfg.peak_level = 0;
        cfg.use_cones = 1'b1;
        cfg.peak_count = 1;
        cfg.global_count = 1;
        hits = 0;
        evals = 0;
        foreach (covered[i]) covered[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of every field
        reg_write(REG_COUNT, 4);
        reg_write(REG_GLOBAL, 2);
        push_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_load(2, 32'h0001_0000, 32'h0000_0000, 0, 0);
        push_load(3, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001);
        push_eval(0, 0);
        push_eval(32'h7FFF_FFFF, 32'h8000_0000);
        push_eval(32'h8000_0000, 32'h7FFF_FFFF);
        push_eval(32'hFFFF_FFFF, 1);
        push_op(OP_SPARE);
        push_op(OP_CLOSE);
        drain();
        reg_write(REG_CONES, 0);
        reg_write(REG_BOTTOM, 32'h8000_0000);
        reg_write(REG_LEVEL, 32'h8000_0000);
        push_eval(0, 0);
        push_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_load(63, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        push_op(OP_CLOSE);
        drain();
        reg_write(REG_COUNT, 0);
        push_eval(5, 5);
        push_op(OP_CLOSE);
        drain();

        reg_write(REG_COUNT, 64);
        reg_write(REG_GLOBAL, 64);
        reg_write(REG_BOTTOM, 32'h7FFF_FFFF);
        reg_write(REG_LEVEL, 32'h7FFF_FFFF);
        load_all();
        push_eval(0, 0);
        push_op(OP_CLOSE);
        drain();

        // random phases
        total = 0;
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(REG_CONES, $urandom_range(0, 1));
            reg_write(REG_COUNT, ph == 3 ? 127 : $urandom_range(1, 8));
            reg_write(REG_GLOBAL, ph == 4 ? 100 : $urandom_range(0, 8));
            reg_write(REG_BOTTOM, $urandom_range(0, 3) == 0 ? $urandom
                      : -$urandom_range(0, 32'h0100_0000));
            reg_write(REG_LEVEL, $urandom_range(0, 3) == 0 ? $urandom
                      : $urandom_range(0, 32'h0080_0000));
            if (ph == 11) quiet = 1;
            phase_n = 0;
            while (phase_n < 100) begin
                if ($urandom_range(0, 19) == 0)
                    push_load($urandom_range(0, 63), $urandom_range(0, 32'h00FF_FFFF),
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                        rnd_coord(32'h0080_0000), rnd_coord(32'h0080_0000));
                else if ($urandom_range(0, 29) == 0)
                    push_op($urandom_range(0, 1) ? OP_CLOSE : OP_SPARE);
                else begin
                    push_eval(rnd_coord(32'h0080_0000), rnd_coord(32'h0080_0000));
                    phase_n++;
                end
            end
            push_op(OP_CLOSE);
            if (ph == 2) begin
                hold_out = 1;
                wait (hold_out_cycles >= 2000);
                hold_out = 0;
            end
            drain();
            total += phase_n;
        end

        $display("sent %0d requests (%0d evals, %0d closes), %0d results, %0d hits",
            n_sent, n_eval, n_close, n_recv, n_hit);
        $display("random phases evaluated %0d points across cone and squared modes",
            total);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
